### hdl/wog_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wog_pkg: shared types and constants for the wavetable oscillator with glide
// Item and result structs, op codes, the classified command passed from the
// front queue to the back sequencer, and fixed arithmetic constants.
// ----------------------------------------------------------------------------
package wog_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 4096;
	localparam int unsigned SAMPLE_WIDTH    = 16;
	localparam int unsigned GLIDE_STEPS     = 10;
	localparam int unsigned RAMP_STEPS      = 100;

	// pi in Q30, used when the sine table is built
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	// floor(x / 10) and floor(x / 100) for any 32-bit x by reciprocal multiply
	localparam logic [31:0] DIV10_MAGIC  = 32'hCCCCCCCD;
	localparam int unsigned DIV10_SHIFT  = 35;
	localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;
	localparam int unsigned DIV100_SHIFT = 37;

	localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_SET_FREQ = 2'd1,
		OP_SET_AMP  = 2'd2,
		OP_SET_PLAY = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		K_TICK,
		K_FREQ,
		K_REJECT,
		K_AMP,
		K_PLAY
	} kind_t;

	typedef struct packed {
		op_t                 op;
		logic signed [15:0]  in_sample;
		logic [31:0]         tuning_word;
		logic [15:0]         amp_target;
		logic                play_flag;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] out_sample;
		logic                           status;
		logic [31:0]                    current_tuning;
		logic [15:0]                    current_amp;
	} out_item_t;

	typedef struct packed {
		kind_t               kind;
		logic signed [15:0]  smp;
		logic [31:0]         value;
		logic                play;
	} cmd_t;

endpackage
`default_nettype wire

### hdl/wavetable_oscillator_glide_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wavetable_oscillator_glide_top: sine oscillator with glide and ramp
// Phase-accumulator sine oscillator with a linearly interpolated table,
// frequency glide, amplitude ramp and input mix with saturation.
//
//   channel   direction  handshake           payload
//   item      in         push / full         wog_pkg::in_item_t
//   result    out        pop / empty         wog_pkg::out_item_t
//
// A playing tick passes from the front queue through the glide, phase,
// multiply, table read, interpolate, value, scale and mix states; glide and
// ramp commands through abs, divide and set; the back handles one at a time.
// The sine table is a constant ROM, so reset needs no clearing pass.
// The front queue holds two items; full rises when both are held. A result
// waits in the output register until popped, and the back stalls behind it.
// ----------------------------------------------------------------------------
module wavetable_oscillator_glide_top #(
	parameter int unsigned TABLE_DEPTH = wog_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire wog_pkg::in_item_t item,
	output logic                   empty,
	input  wire logic              pop,
	output wog_pkg::out_item_t     result
);
	import wog_pkg::*;

	logic q_valid;
	cmd_t q_cmd;
	logic deq;

	wog_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.deq     (deq),
		.q_valid (q_valid),
		.q_cmd   (q_cmd)
	);

	wog_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.deq     (deq),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule
`default_nettype wire

### hdl/wog_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wog_front: input queue and classifier
// Accepts items, sorts them into tick, glide, rejected glide, ramp and play
// commands, and holds up to two of them for the back sequencer.
// ----------------------------------------------------------------------------
module wog_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire wog_pkg::in_item_t item,
	input  wire logic             deq,
	output logic                  q_valid,
	output wog_pkg::cmd_t         q_cmd
);
	import wog_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       cls;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		cls.smp   = item.in_sample;
		cls.value = 32'(item.tuning_word);
		cls.play  = item.play_flag;
		case (item.op)
			OP_TICK: begin
				cls.kind = K_TICK;
			end
			OP_SET_FREQ: begin
				// a tuning word of half the phase range or more is refused
				cls.kind = item.tuning_word[31] ? K_REJECT : K_FREQ;
			end
			OP_SET_AMP: begin
				cls.kind  = K_AMP;
				cls.value = {16'd0, item.amp_target};
			end
			OP_SET_PLAY: begin
				cls.kind = K_PLAY;
			end
			default: begin
				cls.kind = K_TICK;
			end
		endcase
	end

	assign full    = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign q_cmd   = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = deq && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/wog_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wog_back: oscillator state, sine table and sequencer
// Takes one classified item at a time, steps glide, phase and ramp, reads and
// interpolates the sine table, scales and mixes, and holds the result.
// ----------------------------------------------------------------------------
module wog_back #(
	parameter int unsigned TABLE_DEPTH = wog_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  wire wog_pkg::cmd_t q_cmd,
	output logic               deq,
	input  wire logic          pop,
	output logic               empty,
	output wog_pkg::out_item_t result
);
	import wog_pkg::*;

	localparam int unsigned SW      = SAMPLE_WIDTH;
	localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH);
	localparam int unsigned DEPTH_W = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned IP_W    = SW + 18;

	localparam logic [63:0]         DEPTH_64   = 64'(TABLE_DEPTH);
	localparam logic [63:0]         TWO_DEPTH  = 64'(2 * TABLE_DEPTH);
	localparam logic [63:0]         THREE_DEPTH = 64'(3 * TABLE_DEPTH);
	localparam logic [63:0]         FOUR_DEPTH = 64'(4 * TABLE_DEPTH);
	localparam logic signed [63:0]  FULL_SCALE = 64'((64'd1 << (SW - 1)) - 64'd1);
	localparam logic [DEPTH_W-1:0]  DEPTH_MUL  = DEPTH_W'(TABLE_DEPTH);
	localparam logic [IDX_W-1:0]    LAST_IDX   = IDX_W'(TABLE_DEPTH - 1);
	localparam logic signed [SW+1:0] MIX_MAX   = $signed({3'b000, {(SW-1){1'b1}}});
	localparam logic signed [SW+1:0] MIX_MIN   = $signed({3'b111, {(SW-1){1'b0}}});

	typedef logic signed [SW-1:0] rom_t [TABLE_DEPTH];

	// Quarter-wave odd Taylor series in Q30, rounded to full scale.
	function automatic logic signed [SW-1:0] sine_entry(input logic [63:0] i);
		logic [63:0]        f;
		logic [63:0]        k;
		logic               neg;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic signed [63:0] mag;
		f = i << 2;
		if (f <= DEPTH_64) begin
			k   = f;
			neg = 1'b0;
		end else if (f <= TWO_DEPTH) begin
			k   = TWO_DEPTH - f;
			neg = 1'b0;
		end else if (f <= THREE_DEPTH) begin
			k   = f - TWO_DEPTH;
			neg = 1'b1;
		end else begin
			k   = FOUR_DEPTH - f;
			neg = 1'b1;
		end
		x    = (PI_Q30 * k) / TWO_DEPTH;
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd342; sum = sum - $signed(term);
		if (sum < 0) begin
			sum = 0;
		end
		mag = (sum * FULL_SCALE + (64'sd1 <<< 29)) >>> 30;
		if (mag > FULL_SCALE) begin
			mag = FULL_SCALE;
		end
		return neg ? SW'(-mag) : SW'(mag);
	endfunction

	function automatic rom_t build_rom();
		rom_t r;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			r[i] = sine_entry(64'(i));
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ABS,
		ST_DIV,
		ST_SET,
		ST_GLIDE,
		ST_PHASE,
		ST_MULP,
		ST_ROM,
		ST_INTERP,
		ST_VAL,
		ST_SCALE,
		ST_MIX,
		ST_EMIT
	} state_t;

	state_t state_q;

	// oscillator state
	logic [31:0]        phase_q;
	logic [31:0]        cur_incr_q;
	logic [31:0]        target_incr_q;
	logic signed [32:0] incr_step_q;
	logic [15:0]        cur_amp_q;
	logic [15:0]        goal_amp_q;
	logic signed [16:0] amp_step_q;
	logic               is_playing_q;

	out_item_t res_q;
	out_item_t out_q;
	logic      out_valid_q;

	// sequencer datapath
	cmd_t                       item_q;
	logic                       neg_q;
	logic [31:0]                divin_q;
	logic [63:0]                prod_q;
	logic [32+DEPTH_W-1:0]      pmul_q;
	logic signed [SW-1:0]       rom_a_q;
	logic signed [SW-1:0]       rom_b_q;
	logic [15:0]                frac_q;
	logic signed [IP_W-1:0]     iprod_q;
	logic signed [SW:0]         val_q;
	logic signed [SW+17:0]      sprod_q;

	logic signed [32:0]   freq_diff;
	logic [32:0]          freq_mag;
	logic signed [16:0]   amp_diff;
	logic [16:0]          amp_mag;
	logic [32:0]          freq_quot;
	logic signed [32:0]   freq_step_new;
	logic [16:0]          amp_quot;
	logic signed [16:0]   amp_step_new;

	logic signed [32:0]   glide_diff;
	logic [32:0]          glide_mag;
	logic [32:0]          glide_step_mag;
	logic [31:0]          glide_next;
	logic signed [16:0]   ramp_diff;
	logic [16:0]          ramp_mag;
	logic [16:0]          ramp_step_mag;
	logic [15:0]          ramp_next;

	logic [IDX_W-1:0]     idx;
	logic [IDX_W-1:0]     nxt;
	logic signed [SW:0]   rom_diff;
	logic signed [16:0]   frac_s;
	logic [SW+1:0]        val_sum;
	logic signed [16:0]   amp_s;
	logic signed [SW+1:0] mix;
	logic signed [SW-1:0] sat_sample;
	logic                 emit_ok;

	// step size for a new glide or ramp target
	assign freq_diff = $signed({1'b0, item_q.value} - {1'b0, cur_incr_q});
	assign freq_mag  = freq_diff[32] ? 33'(-freq_diff) : 33'(freq_diff);
	assign amp_diff  = $signed({1'b0, item_q.value[15:0]} - {1'b0, cur_amp_q});
	assign amp_mag   = amp_diff[16] ? 17'(-amp_diff) : 17'(amp_diff);

	assign freq_quot     = 33'(prod_q >> DIV10_SHIFT);
	assign freq_step_new = neg_q ? $signed(-freq_quot) : $signed(freq_quot);
	assign amp_quot      = 17'(prod_q >> DIV100_SHIFT);
	assign amp_step_new  = neg_q ? $signed(-amp_quot) : $signed(amp_quot);

	// move toward the goal, snapping once the step would reach or pass it
	assign glide_diff     = $signed({1'b0, target_incr_q} - {1'b0, cur_incr_q});
	assign glide_mag      = glide_diff[32] ? 33'(-glide_diff) : 33'(glide_diff);
	assign glide_step_mag = incr_step_q[32] ? 33'(-incr_step_q) : 33'(incr_step_q);
	assign glide_next     = (glide_mag > glide_step_mag) ?
		cur_incr_q + incr_step_q[31:0] : target_incr_q;

	assign ramp_diff     = $signed({1'b0, goal_amp_q} - {1'b0, cur_amp_q});
	assign ramp_mag      = ramp_diff[16] ? 17'(-ramp_diff) : 17'(ramp_diff);
	assign ramp_step_mag = amp_step_q[16] ? 17'(-amp_step_q) : 17'(amp_step_q);
	assign ramp_next     = (ramp_mag > ramp_step_mag) ?
		cur_amp_q + amp_step_q[15:0] : goal_amp_q;

	// table read and interpolation
	assign idx      = pmul_q[32 +: IDX_W];
	assign nxt      = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
	assign rom_diff = $signed({rom_b_q[SW-1], rom_b_q} - {rom_a_q[SW-1], rom_a_q});
	assign frac_s   = $signed({1'b0, frac_q});
	assign val_sum  = {{2{rom_a_q[SW-1]}}, rom_a_q} + iprod_q[IP_W-1:16];
	assign amp_s    = $signed({1'b0, cur_amp_q});

	assign mix        = $signed(sprod_q[SW+17:16]) + $signed(item_q.smp);
	assign sat_sample = (mix > MIX_MAX) ? SAMPLE_MAX :
		(mix < MIX_MIN) ? SAMPLE_MIN : mix[SW-1:0];

	assign deq     = (state_q == ST_IDLE) && q_valid;
	assign emit_ok = !out_valid_q || pop;
	assign empty   = !out_valid_q;
	assign result  = out_q;

	always_ff @(posedge clk) begin
		if (deq) begin
			item_q <= q_cmd;
		end
		case (state_q)
			ST_ABS: begin
				if (item_q.kind == K_FREQ) begin
					neg_q   <= freq_diff[32];
					divin_q <= 32'(freq_mag + 33'(GLIDE_STEPS - 1));
				end else begin
					neg_q   <= amp_diff[16];
					divin_q <= 32'(amp_mag) + 32'(RAMP_STEPS - 1);
				end
			end
			ST_DIV: begin
				prod_q <= 64'(divin_q) *
					64'((item_q.kind == K_FREQ) ? DIV10_MAGIC : DIV100_MAGIC);
			end
			ST_MULP: begin
				pmul_q <= (32+DEPTH_W)'(phase_q) * (32+DEPTH_W)'(DEPTH_MUL);
			end
			ST_ROM: begin
				rom_a_q <= SINE_ROM[idx];
				rom_b_q <= SINE_ROM[nxt];
				frac_q  <= pmul_q[31:16];
			end
			ST_INTERP: begin
				iprod_q <= IP_W'(rom_diff) * IP_W'(frac_s);
			end
			ST_VAL: begin
				val_q <= $signed(val_sum[SW:0]);
			end
			ST_SCALE: begin
				sprod_q <= (SW+18)'(val_q) * (SW+18)'(amp_s);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			phase_q       <= '0;
			cur_incr_q    <= '0;
			target_incr_q <= '0;
			incr_step_q   <= '0;
			cur_amp_q     <= '0;
			goal_amp_q    <= '0;
			amp_step_q    <= '0;
			is_playing_q  <= 1'b0;
			res_q         <= '0;
			out_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if ((state_q == ST_EMIT) && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						// stopped: pass the input through
						res_q.out_sample     <= ((q_cmd.kind == K_TICK) && !is_playing_q) ?
							SW'(q_cmd.smp) : '0;
						res_q.status         <= (q_cmd.kind == K_REJECT) ?
							STATUS_RANGE : STATUS_OK;
						res_q.current_tuning <= cur_incr_q;
						res_q.current_amp    <= cur_amp_q;
						case (q_cmd.kind)
							K_TICK: begin
								if (is_playing_q) begin
									state_q <= ST_GLIDE;
								end else begin
									state_q <= ST_EMIT;
								end
							end
							K_REJECT: begin
								state_q <= ST_EMIT;
							end
							K_PLAY: begin
								is_playing_q <= q_cmd.play;
								state_q      <= ST_EMIT;
							end
							K_FREQ, K_AMP: begin
								state_q <= ST_ABS;
							end
							default: begin
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_ABS: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					state_q <= ST_SET;
				end
				ST_SET: begin
					if (item_q.kind == K_FREQ) begin
						incr_step_q   <= freq_step_new;
						target_incr_q <= item_q.value;
					end else begin
						amp_step_q <= amp_step_new;
						goal_amp_q <= item_q.value[15:0];
					end
					state_q <= ST_EMIT;
				end
				ST_GLIDE: begin
					cur_incr_q <= glide_next;
					cur_amp_q  <= ramp_next;
					state_q    <= ST_PHASE;
				end
				ST_PHASE: begin
					phase_q <= phase_q + cur_incr_q;
					state_q <= ST_MULP;
				end
				ST_MULP: begin
					state_q <= ST_ROM;
				end
				ST_ROM: begin
					state_q <= ST_INTERP;
				end
				ST_INTERP: begin
					state_q <= ST_VAL;
				end
				ST_VAL: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_MIX;
				end
				ST_MIX: begin
					res_q.out_sample     <= sat_sample;
					res_q.status         <= STATUS_OK;
					res_q.current_tuning <= cur_incr_q;
					res_q.current_amp    <= cur_amp_q;
					state_q              <= ST_EMIT;
				end
				ST_EMIT: begin
					// hold until the result register is free or being taken
					if (emit_ok) begin
						out_q   <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: regression for wavetable_oscillator_glide_top
// A scoreboard predicts every result: it builds its own sine table and steps
// the glide, the ramp and the phase. Directed items cover the corner cases.
// Then 740 random items follow, under four send/receive idling mixes and one
// long receiver hold-off that fills the block.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import wog_pkg::*;

	localparam int unsigned      TBL_DEPTH        = TABLE_DEPTH_DEF;
	localparam longint unsigned  TBL_N            = TBL_DEPTH;
	localparam longint           FULL_SCALE       = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
	localparam int               RANDOM_PER_PHASE = 185;
	localparam int               HOLD_CYCLES      = 60;
	localparam int               DRAIN_CYCLES     = 20;
	localparam int               CYCLE_LIMIT      = 200000;

	class osc_scoreboard;
		longint      sine_lut[TBL_DEPTH];
		bit [31:0]   phase_acc;
		bit [31:0]   incr_now;
		bit [31:0]   incr_goal;
		longint      incr_step;
		bit [15:0]   amp_now;
		bit [15:0]   amp_goal;
		longint      amp_step;
		bit          playing;
		out_item_t   expected_q[$];
		int          mismatches;
		int          checked;
		int          played_ticks;
		int          rejected;

		function new();
			longint unsigned f, k, x, x2, term;
			longint          sum, mag;
			bit              neg;
			for (int i = 0; i < TBL_DEPTH; i++) begin
				f = longint'(4 * i);
				// fold onto the first quadrant
				if (f <= TBL_N) begin
					k = f;
					neg = 1'b0;
				end else if (f <= 2 * TBL_N) begin
					k = 2 * TBL_N - f;
					neg = 1'b0;
				end else if (f <= 3 * TBL_N) begin
					k = f - 2 * TBL_N;
					neg = 1'b1;
				end else begin
					k = 4 * TBL_N - f;
					neg = 1'b1;
				end
				x = (PI_Q30 * k) / (2 * TBL_N);
				x2 = (x * x) >> 30;
				term = x;
				sum = longint'(x);
				for (int t = 1; t < 10; t++) begin
					term = (term * x2) >> 30;
					term = term / longint'((2 * t) * (2 * t + 1));
					if (t % 2 == 1)
						sum -= longint'(term);
					else
						sum += longint'(term);
				end
				if (sum < 0)
					sum = 0;
				mag = (sum * FULL_SCALE + (longint'(1) << 29)) >>> 30;
				if (mag > FULL_SCALE)
					mag = FULL_SCALE;
				sine_lut[i] = neg ? -mag : mag;
			end
			mismatches = 0;
			checked = 0;
			played_ticks = 0;
			rejected = 0;
		endfunction

		function longint step_toward(longint cur, longint goal, longint stp);
			longint d, ad, as_;
			d = goal - cur;
			ad = (d < 0) ? -d : d;
			as_ = (stp < 0) ? -stp : stp;
			return (ad > as_) ? cur + stp : goal;
		endfunction

		function longint glide_step(longint diff, longint n);
			longint mag, s;
			mag = (diff < 0) ? -diff : diff;
			s = (mag + n - 1) / n;
			return (diff < 0) ? -s : s;
		endfunction

		function void note_item(in_item_t it);
			out_item_t exp;
			longint    p, idx, nxt, frac, a, b, val, res;
			shortint   smp;
			exp = '0;
			exp.status = STATUS_OK;
			res = 0;
			smp = it.in_sample;
			case (it.op)
				OP_TICK: begin
					if (playing) begin
						played_ticks++;
						incr_now = 32'(step_toward(longint'(incr_now), longint'(incr_goal),
							incr_step));
						phase_acc = phase_acc + incr_now;
						amp_now = 16'(step_toward(longint'(amp_now), longint'(amp_goal),
							amp_step));
						p = longint'(phase_acc) * longint'(TBL_DEPTH);
						idx = p >> 32;
						if (idx >= TBL_DEPTH)
							idx = TBL_DEPTH - 1;
						nxt = (idx + 1 >= TBL_DEPTH) ? 0 : idx + 1;
						frac = (p >> 16) & 64'hFFFF;
						a = sine_lut[idx];
						b = sine_lut[nxt];
						val = a + (((b - a) * frac) >>> 16);
						res = (val * longint'(amp_now)) >>> 16;
					end
					res += longint'(smp);
					if (res > FULL_SCALE)
						res = FULL_SCALE;
					if (res < -FULL_SCALE - 1)
						res = -FULL_SCALE - 1;
				end
				OP_SET_FREQ: begin
					if (it.tuning_word[31]) begin
						exp.status = STATUS_RANGE;
						rejected++;
					end else begin
						incr_step = glide_step(longint'(it.tuning_word) - longint'(incr_now),
							GLIDE_STEPS);
						incr_goal = it.tuning_word;
					end
				end
				OP_SET_AMP: begin
					amp_step = glide_step(longint'(it.amp_target) - longint'(amp_now),
						RAMP_STEPS);
					amp_goal = it.amp_target;
				end
				default: begin
					playing = it.play_flag;
				end
			endcase
			exp.out_sample = res[SAMPLE_WIDTH-1:0];
			exp.current_tuning = incr_now;
			exp.current_amp = amp_now;
			expected_q.push_back(exp);
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp;
			if (expected_q.size() == 0) begin
				$error("result transfer with no expectation waiting");
				mismatches++;
				return;
			end
			exp = expected_q.pop_front();
			checked++;
			if (got.out_sample !== exp.out_sample) begin
				$error("out_sample: expected %0d, got %0d", exp.out_sample, got.out_sample);
				mismatches++;
			end
			if (got.status !== exp.status) begin
				$error("status: expected %0d, got %0d", exp.status, got.status);
				mismatches++;
			end
			if (got.current_tuning !== exp.current_tuning) begin
				$error("current_tuning: expected %h, got %h", exp.current_tuning,
					got.current_tuning);
				mismatches++;
			end
			if (got.current_amp !== exp.current_amp) begin
				$error("current_amp: expected %h, got %h", exp.current_amp, got.current_amp);
				mismatches++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	in_item_t   item = '0;
	logic       empty;
	logic       pop = 1'b0;
	out_item_t  result;

	osc_scoreboard osc_sb = new();

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int input_stalls = 0;
	int cycle_count = 0;
	int items_sent = 0;

	wavetable_oscillator_glide_top dut (
		.clk,
		.arst_n,
		.push,
		.full,
		.item,
		.empty,
		.pop,
		.result
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Cycle limit reached with %0d results outstanding",
				osc_sb.expected_q.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: check each transfer, stall at random, or hold off for a long stretch
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty)
				osc_sb.check_result(result);
			if (push && full)
				input_stalls++;
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		osc_sb.note_item(it);
		items_sent++;
	endtask

	function automatic in_item_t make_cmd(op_t op, logic signed [15:0] smp,
			logic [31:0] tw, logic [15:0] amp, logic pf);
		in_item_t it;
		it.op = op;
		it.in_sample = smp;
		it.tuning_word = tw;
		it.amp_target = amp;
		it.play_flag = pf;
		return it;
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int       pick;
		it.in_sample = 16'($urandom);
		it.tuning_word = $urandom;
		it.amp_target = 16'($urandom);
		it.play_flag = 1'($urandom);
		pick = $urandom_range(99);
		if (pick < 62)
			it.op = OP_TICK;
		else if (pick < 74)
			it.op = OP_SET_FREQ;
		else if (pick < 86)
			it.op = OP_SET_AMP;
		else begin
			it.op = OP_SET_PLAY;
			// mostly keep playing so ticks reach the glide and ramp
			it.play_flag = ($urandom_range(99) < 80);
		end
		case ($urandom_range(9))
			0:       it.tuning_word = $urandom;
			1:       it.tuning_word = 32'h8000_0000 | $urandom;
			2:       it.tuning_word = 32'h7FFF_FFFF - $urandom_range(255);
			default: it.tuning_word = ($urandom >> 1) >> $urandom_range(20);
		endcase
		case ($urandom_range(9))
			0:       it.in_sample = 16'sh7FFF;
			1:       it.in_sample = 16'sh8000;
			default: ;
		endcase
		case ($urandom_range(9))
			0:       it.amp_target = 16'h0000;
			1:       it.amp_target = 16'hFFFF;
			default: ;
		endcase
		return it;
	endfunction

	initial begin
		while (!arst_n)
			@(posedge clk);
		@(posedge clk);

		// stopped: pass through, commands take effect without stepping
		send_item(make_cmd(OP_TICK, 16'sh7FFF, 32'h0, 16'h0, 1'b0));
		send_item(make_cmd(OP_TICK, 16'sh8000, 32'h0, 16'h0, 1'b0));
		send_item(make_cmd(OP_SET_PLAY, 16'sh0, 32'h0, 16'h0, 1'b0));
		send_item(make_cmd(OP_SET_FREQ, 16'sh0, 32'h7FFF_FFFF, 16'h0, 1'b0));
		send_item(make_cmd(OP_SET_FREQ, 16'sh0, 32'h8000_0000, 16'h0, 1'b0));
		send_item(make_cmd(OP_SET_FREQ, 16'sh0, 32'hFFFF_FFFF, 16'h0, 1'b0));
		send_item(make_cmd(OP_SET_AMP, 16'sh0, 32'h0, 16'hFFFF, 1'b0));
		send_item(make_cmd(OP_TICK, 16'sh0, 32'h0, 16'h0, 1'b0));
		send_item(make_cmd(OP_SET_PLAY, 16'sh0, 32'h0, 16'h0, 1'b1));
		// playing: saturate both ways while the glide and ramp run
		send_item(make_cmd(OP_TICK, 16'sh7FFF, 32'h0, 16'h0, 1'b0));
		send_item(make_cmd(OP_TICK, 16'sh8000, 32'h0, 16'h0, 1'b0));
		send_item(make_cmd(OP_TICK, 16'sh0, 32'h0, 16'h0, 1'b0));
		send_item(make_cmd(OP_TICK, 16'sh3039, 32'h0, 16'h0, 1'b0));
		send_item(make_cmd(OP_SET_FREQ, 16'sh0, 32'h0, 16'h0, 1'b0));
		send_item(make_cmd(OP_SET_AMP, 16'sh0, 32'h0, 16'h0, 1'b0));
		repeat (3)
			send_item(make_cmd(OP_TICK, 16'sh0, 32'h0, 16'h0, 1'b0));
		send_item(make_cmd(OP_SET_FREQ, 16'sh0, 32'h1, 16'h0, 1'b0));
		send_item(make_cmd(OP_SET_AMP, 16'sh0, 32'h0, 16'h1, 1'b0));
		repeat (2)
			send_item(make_cmd(OP_TICK, 16'sh0, 32'h0, 16'h0, 1'b0));
		send_item(make_cmd(OP_SET_PLAY, 16'sh0, 32'h0, 16'h0, 1'b0));
		send_item(make_cmd(OP_TICK, 16'sh1234, 32'h0, 16'h0, 1'b0));
		send_item(make_cmd(OP_SET_PLAY, 16'sh0, 32'h0, 16'h0, 1'b1));

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 50;
					// long hold-off while the sender keeps offering
					hold_req = 1'b1;
				end
				default: begin send_idle_pct = 38; recv_stall_pct = 38; end
			endcase
			repeat (RANDOM_PER_PHASE)
				send_item(random_item());
		end
		push <= 1'b0;

		while (osc_sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("Sent %0d items: %0d playing ticks, %0d rejected tuning words",
			items_sent, osc_sb.played_ticks, osc_sb.rejected);
		$display("Checked %0d results; input held off by full for %0d cycles; %0d mismatches",
			osc_sb.checked, input_stalls, osc_sb.mismatches);
		if (osc_sb.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### filelist.f
hdl/wog_pkg.sv
hdl/wog_front.sv
hdl/wog_back.sv
hdl/wavetable_oscillator_glide_top.sv
sim/testbench.sv
